### rtl/core/cpfc_pkg.sv
package cpfc_pkg;

  localparam int unsigned ByteCountWidth = 18;
  localparam logic [ByteCountWidth-1:0] ByteCountMax = '1;
  localparam logic [7:0] LowNibble = 8'h0F;
  localparam int unsigned QueueDepthDefault = 2;

  typedef enum logic [2:0] {
    SRC_MONO8 = 3'd0,
    SRC_MONO12 = 3'd1,
    SRC_MONO16 = 3'd2,
    SRC_MONO32 = 3'd3,
    SRC_MONO12P = 3'd4
  } src_fmt_t;

  typedef enum logic [2:0] {
    RES_U8 = 3'd0,
    RES_U16 = 3'd1,
    RES_U32 = 3'd2,
    RES_F32 = 3'd3,
    RES_F64 = 3'd4
  } res_fmt_t;

  typedef enum logic [2:0] {
    REG_SOURCE_FORMAT = 3'd0,
    REG_RESULT_FORMAT = 3'd1,
    REG_ROW_PIXELS = 3'd2,
    REG_ROW_COUNT = 3'd3,
    REG_ROW_STRIDE = 3'd4
  } reg_idx_t;

  // One unpacked pixel waiting for conversion.
  typedef struct packed {
    logic [31:0] value;
    logic        eor;
    logic        eof;
  } pix_item_t;

  // Position of the highest set bit of a nonzero 32-bit word.
  function automatic logic [4:0] msb_pos(input logic [31:0] v);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) begin
        p = 5'(i);
      end
    end
    return p;
  endfunction

endpackage

### rtl/core/cpfc_stream_if.sv
interface cpfc_stream_if #(
  parameter int unsigned Width = 8
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/core/cpfc_cfg_if.sv
interface cpfc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/core/cpfc_unpack.sv
module cpfc_unpack
  import cpfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [2:0]  source_format,
  input  logic [15:0] row_pixels,
  input  logic [15:0] row_count,
  input  logic [17:0] row_stride_bytes,
  input  logic        byte_valid,
  input  logic [7:0]  byte_value,
  output logic        byte_ready,
  output logic        pix_valid,
  output pix_item_t   pix_item,
  input  logic        pix_ready
);

  logic [17:0] byte_in_row_r, byte_in_row_nxt;
  logic [15:0] pixel_in_row_r, pixel_in_row_nxt;
  logic [15:0] row_index_r, row_index_nxt;
  logic [23:0] held_r, held_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic        emit;
  logic [31:0] v;
  logic [15:0] pix_inc;
  logic        last_row;

  assign byte_ready = pix_ready;
  assign last_row = ({1'b0, row_index_r} + 17'd1) >= {1'b0, row_count};

  always_comb begin
    emit = 1'b0;
    v = '0;
    held_nxt = held_r;
    phase_nxt = phase_r;
    if (pixel_in_row_r < row_pixels) begin
      case (source_format)
        SRC_MONO12, SRC_MONO16: begin
          if (phase_r == 2'd0) begin
            held_nxt = {16'd0, byte_value};
            phase_nxt = 2'd1;
          end else begin
            v = {16'd0, byte_value, held_r[7:0]};
            emit = 1'b1;
            phase_nxt = 2'd0;
          end
        end
        SRC_MONO32: begin
          case (phase_r)
            2'd0: begin
              held_nxt = {16'd0, byte_value};
              phase_nxt = 2'd1;
            end
            2'd1: begin
              held_nxt = {held_r[23:16], byte_value, held_r[7:0]};
              phase_nxt = 2'd2;
            end
            2'd2: begin
              held_nxt = {byte_value, held_r[15:0]};
              phase_nxt = 2'd3;
            end
            default: begin
              v = {byte_value, held_r};
              emit = 1'b1;
              phase_nxt = 2'd0;
            end
          endcase
        end
        SRC_MONO12P: begin
          if (phase_r == 2'd1) begin
            held_nxt = {8'd0, byte_value, held_r[7:0]};
            v = {20'd0, held_r[7:0], byte_value[3:0] & LowNibble[3:0]};
            emit = 1'b1;
            phase_nxt = ({1'b0, pixel_in_row_r} + 17'd1 < {1'b0, row_pixels}) ? 2'd2 : 2'd0;
          end else if (phase_r == 2'd2) begin
            v = {20'd0, byte_value, held_r[15:12]};
            emit = 1'b1;
            phase_nxt = 2'd0;
          end else begin
            held_nxt = {16'd0, byte_value};
            phase_nxt = 2'd1;
          end
        end
        default: begin
          v = {24'd0, byte_value};
          emit = 1'b1;
        end
      endcase
    end

    pix_inc = pixel_in_row_r + 16'(emit);
    pixel_in_row_nxt = pix_inc;
    byte_in_row_nxt = (byte_in_row_r != ByteCountMax) ? byte_in_row_r + 18'd1 : byte_in_row_r;
    row_index_nxt = row_index_r;
    if (pix_inc >= row_pixels && byte_in_row_nxt >= row_stride_bytes) begin
      byte_in_row_nxt = '0;
      pixel_in_row_nxt = '0;
      held_nxt = '0;
      phase_nxt = '0;
      row_index_nxt = last_row ? 16'd0 : row_index_r + 16'd1;
    end
  end

  assign pix_valid = byte_valid && emit;
  assign pix_item.value = v;
  assign pix_item.eor = pix_inc >= row_pixels;
  assign pix_item.eof = (pix_inc >= row_pixels) && last_row;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_in_row_r <= '0;
      pixel_in_row_r <= '0;
      row_index_r <= '0;
      held_r <= '0;
      phase_r <= '0;
    end else if (byte_valid && byte_ready) begin
      byte_in_row_r <= byte_in_row_nxt;
      pixel_in_row_r <= pixel_in_row_nxt;
      row_index_r <= row_index_nxt;
      held_r <= held_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

### rtl/core/cpfc_queue.sv
module cpfc_queue
  import cpfc_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  input  pix_item_t push_item,
  output logic      push_ready,
  output logic      pop_valid,
  output pix_item_t pop_item,
  input  logic      pop_ready
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  pix_item_t          mem_r [Depth];
  logic [PtrW-1:0]    wr_r, rd_r;
  logic [PtrW:0]      cnt_r;
  logic               push, pop;

  assign push_ready = cnt_r != (PtrW+1)'(Depth);
  assign pop_valid = cnt_r != '0;
  assign pop_item = mem_r[rd_r];
  assign push = push_valid && push_ready;
  assign pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == PtrW'(Depth - 1)) ? '0 : wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= (rd_r == PtrW'(Depth - 1)) ? '0 : rd_r + 1'b1;
      end
      cnt_r <= cnt_r + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

endmodule

### rtl/core/cpfc_encode.sv
module cpfc_encode
  import cpfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [2:0]  result_format,
  input  logic        pix_valid,
  input  pix_item_t   pix_item,
  output logic        pix_ready,
  output logic        out_valid,
  output logic [63:0] out_pixel_value,
  output logic        out_end_of_row,
  output logic        out_end_of_frame,
  input  logic        out_ready
);

  // Stage 1 finds the leading one, stage 2 shifts and rounds, stage 3 holds the result.
  logic        s1_v_r, s2_v_r;
  pix_item_t   s1_r, s2_r;
  logic [4:0]  s2_pos_r;
  logic        s2_zero_r;
  logic [63:0] res_nxt;
  logic        adv2, adv1, adv0;
  logic [31:0] norm;
  logic [23:0] mant;
  logic        guard, sticky, up;
  logic [24:0] mant_r;
  logic [7:0]  e32;
  logic [31:0] f32;
  logic [63:0] f64;

  assign adv2 = !out_valid || out_ready;
  assign adv1 = !s2_v_r || adv2;
  assign adv0 = !s1_v_r || adv1;
  assign pix_ready = adv0;

  always_comb begin
    norm = s2_r.value << (5'd31 - s2_pos_r);
    mant = norm[31:8];
    guard = norm[7];
    sticky = |norm[6:0];
    up = guard && (sticky || mant[0]);
    mant_r = {1'b0, mant} + 25'(up);
    e32 = 8'd127 + {3'd0, s2_pos_r} + 8'(mant_r[24]);
    f32 = s2_zero_r ? 32'd0 : {1'b0, e32, mant_r[24] ? 23'd0 : mant_r[22:0]};
    f64 = s2_zero_r ? 64'd0 :
          {1'b0, 11'd1023 + {6'd0, s2_pos_r}, norm[30:0], 21'd0};
    case (result_format)
      RES_U16: res_nxt = {48'd0, s2_r.value[15:0]};
      RES_U32: res_nxt = {32'd0, s2_r.value};
      RES_F32: res_nxt = {32'd0, f32};
      RES_F64: res_nxt = f64;
      default: res_nxt = {56'd0, s2_r.value[7:0]};
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv0) begin
      s1_r <= pix_item;
    end
    if (adv1) begin
      s2_r <= s1_r;
      s2_pos_r <= msb_pos(s1_r.value);
      s2_zero_r <= s1_r.value == '0;
    end
    if (adv2) begin
      out_pixel_value <= res_nxt;
      out_end_of_row <= s2_r.eor;
      out_end_of_frame <= s2_r.eof;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv0) s1_v_r <= pix_valid;
      if (adv1) s2_v_r <= s1_v_r;
      if (adv2) out_valid <= s2_v_r;
    end
  end

endmodule

### rtl/core/camera_pixel_format_converter_unit.sv
// Channel | Direction | Payload
// in_     | sink      | byte_value [7:0]
// out_    | source    | pixel_value [63:0], end_of_row, end_of_frame
// cfg_    | sink      | index [2:0], data [31:0]
// One byte is taken per cycle while in_ready is high; the unpacker decides in that cycle whether a pixel completes.
// Pixels cross a small queue into a three-stage converter (leading one, round, output).
// From the completing byte, a pixel is registered in the queue, then in stages 1 and 2 and the output register.
// Reset is synchronous on rst_n and clears all counters, the queue and the pipeline valids.
// A stalled output stops the converter, then the queue fills and in_ready drops.
module camera_pixel_format_converter_unit
  import cpfc_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic clk,
  input  logic rst_n,
  cpfc_stream_if.sink in_ch,
  output logic in_ready,
  cpfc_cfg_if.sink cfg,
  output logic        out_valid,
  output logic [63:0] out_pixel_value,
  output logic        out_end_of_row,
  output logic        out_end_of_frame,
  input  logic        out_ready
);

  logic [2:0]  src_fmt_r, res_fmt_r;
  logic [15:0] row_pixels_r, row_count_r;
  logic [17:0] stride_r;
  logic        f_valid, f_ready, b_valid, b_ready;
  pix_item_t   f_item, b_item;

  assign cfg.ready = 1'b1;
  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_fmt_r <= SRC_MONO8;
      res_fmt_r <= RES_U8;
      row_pixels_r <= 16'd1;
      row_count_r <= 16'd1;
      stride_r <= 18'd1;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_SOURCE_FORMAT: src_fmt_r <= cfg.data[2:0];
        REG_RESULT_FORMAT: res_fmt_r <= cfg.data[2:0];
        REG_ROW_PIXELS: row_pixels_r <= cfg.data[15:0];
        REG_ROW_COUNT: row_count_r <= cfg.data[15:0];
        REG_ROW_STRIDE: stride_r <= cfg.data[17:0];
        default: ;
      endcase
    end
  end

  cpfc_unpack u_unpack (
    .clk, .rst_n,
    .source_format(src_fmt_r), .row_pixels(row_pixels_r), .row_count(row_count_r),
    .row_stride_bytes(stride_r),
    .byte_valid(in_ch.valid), .byte_value(in_ch.data), .byte_ready(in_ready),
    .pix_valid(f_valid), .pix_item(f_item), .pix_ready(f_ready)
  );

  cpfc_queue #(.Depth(QueueDepth)) u_queue (
    .clk, .rst_n,
    .push_valid(f_valid), .push_item(f_item), .push_ready(f_ready),
    .pop_valid(b_valid), .pop_item(b_item), .pop_ready(b_ready)
  );

  cpfc_encode u_encode (
    .clk, .rst_n, .result_format(res_fmt_r),
    .pix_valid(b_valid), .pix_item(b_item), .pix_ready(b_ready),
    .out_valid, .out_pixel_value, .out_end_of_row, .out_end_of_frame, .out_ready
  );

endmodule
